// File: src/sas_pkg.sv
// Shared constants, beat types and sequencer states for the sprite animation sequencer.
package sas_pkg;

	localparam int CLIP_DEPTH = 16;
	localparam int CLIP_AW    = $clog2(CLIP_DEPTH);
	localparam int MAX_FRAMES = 256;
	localparam int FRAME_W    = $clog2(MAX_FRAMES);
	localparam int TIME_W     = 16;
	localparam int ELAPSED_W  = 17;
	localparam int LEN_W      = 5;
	localparam int SHEET_W    = 9;
	localparam int PADDR_W    = 5;
	localparam int DIV_W      = 18;
	localparam int DIV_CNT_W  = 5;
	localparam int PROD_W     = SHEET_W + TIME_W;

	typedef enum logic [2:0] {
		REG_CLIP_MODE,
		REG_START_FRAME,
		REG_END_FRAME,
		REG_LOOP_ENABLE,
		REG_FRAME_DURATION,
		REG_CLIP_LENGTH,
		REG_SHEET_COLUMNS,
		REG_SHEET_ROWS
	} reg_idx_t;

	typedef enum logic {
		FUNC_ADVANCE,
		FUNC_LOAD
	} func_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV_TIME,
		S_PLAN,
		S_DIV_WRAP,
		S_WRAP,
		S_SUB,
		S_CLIP_FETCH,
		S_TILE_LOAD,
		S_DIV_TILE,
		S_FINISH
	} seq_state_t;

	typedef struct packed {
		func_t              func;
		logic [TIME_W-1:0]  delta_time;
		logic [CLIP_AW-1:0] entry_slot;
		logic [FRAME_W-1:0] entry_frame;
	} item_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame_index;
		logic [7:0]         tile_column;
		logic [7:0]         tile_row_flipped;
		logic               beyond_sheet;
		logic               finished;
	} result_t;

endpackage

// File: src/sprite_animation_sequencer_unit.sv
// Sprite animation sequencer: playback state, sequencer and shared restoring divider.
// One item is handled at a time, and the item port stalls until its result has been
// loaded into the output register; that register lets the next item in while the
// result still waits. All division work runs through one restoring divider that
// retires one quotient bit per cycle. A clip load item writes its table entry and then
// runs an 8-step divide for the sheet tile. An advance item runs an 18-step divide
// of elapsed time by the frame duration, then the tile divide; in looping playback
// a second 18-step divide may wrap the position between them. A configuration
// write restarts playback once the sequencer is idle, and items are held off
// until that restart has been applied.
module sprite_animation_sequencer_unit import sas_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  item_t              item,
	output logic               result_valid,
	input  logic               result_stall,
	output result_t            result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	// configuration
	logic                 clip_mode_q;
	logic [FRAME_W-1:0]   start_frame_q;
	logic [FRAME_W-1:0]   end_frame_q;
	logic                 loop_enable_q;
	logic [TIME_W-1:0]    frame_duration_q;
	logic [LEN_W-1:0]     clip_length_q;
	logic [SHEET_W-1:0]   sheet_columns_q;
	logic [SHEET_W-1:0]   sheet_rows_q;

	// playback state
	seq_state_t           state_q, state_d;
	logic                 restart_q;
	logic [ELAPSED_W-1:0] elapsed_q;
	logic [FRAME_W-1:0]   cur_q;
	logic [CLIP_AW-1:0]   pos_q;
	logic                 done_q;
	logic [FRAME_W-1:0]   clip_table_q [CLIP_DEPTH];

	// shared divider
	logic [DIV_W-1:0]     quo_q;
	logic [TIME_W-1:0]    rem_q;
	logic [TIME_W-1:0]    divisor_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [PROD_W-1:0]    prod_q;
	logic                 result_valid_q;
	result_t              result_q;

	logic                 cfg_wr;
	reg_idx_t             cfg_idx;
	logic                 acc;
	logic                 out_free;
	logic                 div_run;

	logic [TIME_W-1:0]    dur_eff;
	logic [SHEET_W-1:0]   cols_eff;
	logic [SHEET_W-1:0]   rows_eff;
	logic [LEN_W-1:0]     len_eff;
	logic                 clip_active;
	logic [ELAPSED_W:0]   sum;
	logic [ELAPSED_W-1:0] sum_sat;

	logic [ELAPSED_W-1:0] n;
	logic [CLIP_AW-1:0]   pos_c;
	logic [LEN_W-1:0]     clip_k;
	logic [SHEET_W-1:0]   range_k;
	logic [SHEET_W-1:0]   k_sel;
	logic                 n_lt_k;
	logic [PROD_W-1:0]    prod_c;
	logic [FRAME_W-1:0]   off;
	logic [SHEET_W-1:0]   span;
	logic [DIV_W-1:0]     wrap_dividend;
	logic [TIME_W-1:0]    wrap_divisor;

	logic [TIME_W:0]      trial;
	logic                 ge;
	logic [TIME_W:0]      trial_sub;

	logic [FRAME_W-1:0]   row;
	logic                 beyond;
	logic [SHEET_W-1:0]   flip9;
	logic [7:0]           flipped;

	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = reg_idx_t'(paddr[4:2]);

	assign dur_eff     = (frame_duration_q == '0) ? TIME_W'(1) : frame_duration_q;
	assign cols_eff    = (sheet_columns_q == '0) ? SHEET_W'(1) : sheet_columns_q;
	assign rows_eff    = (sheet_rows_q == '0) ? SHEET_W'(1) : sheet_rows_q;
	assign len_eff     = (clip_length_q > LEN_W'(CLIP_DEPTH)) ? LEN_W'(CLIP_DEPTH) : clip_length_q;
	assign clip_active = clip_mode_q && (len_eff != '0);

	assign sum     = {1'b0, elapsed_q} + (ELAPSED_W+1)'(item.delta_time);
	assign sum_sat = sum[ELAPSED_W] ? '1 : sum[ELAPSED_W-1:0];

	// step planning after the time divide
	assign n       = quo_q[ELAPSED_W-1:0];
	assign pos_c   = ({1'b0, pos_q} >= len_eff) ? CLIP_AW'(len_eff - LEN_W'(1)) : pos_q;
	assign clip_k  = len_eff - LEN_W'(pos_c);
	assign range_k = (cur_q <= end_frame_q) ?
		SHEET_W'(end_frame_q) - SHEET_W'(cur_q) + SHEET_W'(1) : SHEET_W'(1);
	assign k_sel   = clip_active ? SHEET_W'(clip_k) : range_k;
	assign n_lt_k  = n < ELAPSED_W'(k_sel);
	assign prod_c  = PROD_W'(k_sel) * PROD_W'(dur_eff);
	assign off     = (cur_q >= start_frame_q && cur_q <= end_frame_q) ?
		cur_q - start_frame_q : '0;
	assign span    = SHEET_W'(end_frame_q) - SHEET_W'(start_frame_q) + SHEET_W'(1);
	assign wrap_dividend = clip_active ? DIV_W'(pos_c) + DIV_W'(n) : DIV_W'(off) + DIV_W'(n);
	assign wrap_divisor  = clip_active ? TIME_W'(len_eff) : TIME_W'(span);

	// one restoring step
	assign trial     = {rem_q, quo_q[DIV_W-1]};
	assign ge        = trial >= {1'b0, divisor_q};
	assign trial_sub = ge ? trial - {1'b0, divisor_q} : trial;

	// tile position
	assign row     = quo_q[FRAME_W-1:0];
	assign beyond  = SHEET_W'(row) >= rows_eff;
	assign flip9   = rows_eff - SHEET_W'(1) - SHEET_W'(row);
	assign flipped = beyond ? 8'd0 : (flip9 > SHEET_W'(255) ? 8'hFF : flip9[7:0]);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					state_d = (item.func == FUNC_ADVANCE) ? S_DIV_TIME : S_TILE_LOAD;
				end
			end
			S_DIV_TIME: begin
				if (cnt_q == DIV_CNT_W'(1)) begin
					state_d = S_PLAN;
				end
			end
			S_PLAN: begin
				if (clip_active) begin
					if (loop_enable_q) begin
						state_d = S_DIV_WRAP;
					end else if (n_lt_k) begin
						state_d = S_CLIP_FETCH;
					end else begin
						state_d = S_SUB;
					end
				end else if (n == '0) begin
					state_d = S_TILE_LOAD;
				end else if (loop_enable_q) begin
					state_d = (start_frame_q <= end_frame_q) ? S_DIV_WRAP : S_TILE_LOAD;
				end else begin
					state_d = n_lt_k ? S_TILE_LOAD : S_SUB;
				end
			end
			S_DIV_WRAP: begin
				if (cnt_q == DIV_CNT_W'(1)) begin
					state_d = S_WRAP;
				end
			end
			S_WRAP: begin
				state_d = clip_active ? S_CLIP_FETCH : S_TILE_LOAD;
			end
			S_SUB: begin
				state_d = clip_active ? S_CLIP_FETCH : S_TILE_LOAD;
			end
			S_CLIP_FETCH: begin
				state_d = S_TILE_LOAD;
			end
			S_TILE_LOAD: begin
				state_d = S_DIV_TILE;
			end
			S_DIV_TILE: begin
				if (cnt_q == DIV_CNT_W'(1)) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		item_stall = (state_q != S_IDLE) || restart_q;
		acc        = item_valid && !item_stall;
		out_free   = !result_valid_q || !result_stall;
		pready     = 1'b1;
		case (state_q)
			S_DIV_TIME, S_DIV_WRAP, S_DIV_TILE: div_run = 1'b1;
			default:                            div_run = 1'b0;
		endcase
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_comb begin
		prdata = '0;
		case (cfg_idx)
			REG_CLIP_MODE:      prdata = 32'(clip_mode_q);
			REG_START_FRAME:    prdata = 32'(start_frame_q);
			REG_END_FRAME:      prdata = 32'(end_frame_q);
			REG_LOOP_ENABLE:    prdata = 32'(loop_enable_q);
			REG_FRAME_DURATION: prdata = 32'(frame_duration_q);
			REG_CLIP_LENGTH:    prdata = 32'(clip_length_q);
			REG_SHEET_COLUMNS:  prdata = 32'(sheet_columns_q);
			REG_SHEET_ROWS:     prdata = 32'(sheet_rows_q);
			default:            prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_mode_q      <= 1'b0;
			start_frame_q    <= '0;
			end_frame_q      <= '0;
			loop_enable_q    <= 1'b0;
			frame_duration_q <= TIME_W'(10);
			clip_length_q    <= '0;
			sheet_columns_q  <= SHEET_W'(1);
			sheet_rows_q     <= SHEET_W'(1);
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_CLIP_MODE:      clip_mode_q      <= pwdata[0];
				REG_START_FRAME:    start_frame_q    <= pwdata[FRAME_W-1:0];
				REG_END_FRAME:      end_frame_q      <= pwdata[FRAME_W-1:0];
				REG_LOOP_ENABLE:    loop_enable_q    <= pwdata[0];
				REG_FRAME_DURATION: frame_duration_q <= pwdata[TIME_W-1:0];
				REG_CLIP_LENGTH:    clip_length_q    <= pwdata[LEN_W-1:0];
				REG_SHEET_COLUMNS:  sheet_columns_q  <= pwdata[SHEET_W-1:0];
				REG_SHEET_ROWS:     sheet_rows_q     <= pwdata[SHEET_W-1:0];
				default:            clip_mode_q      <= clip_mode_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			restart_q      <= 1'b0;
			elapsed_q      <= '0;
			cur_q          <= '0;
			pos_q          <= '0;
			done_q         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_FINISH && out_free) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			if (cfg_wr) begin
				restart_q <= 1'b1;
			end else if (state_q == S_IDLE) begin
				restart_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (restart_q) begin
						elapsed_q <= '0;
						pos_q     <= '0;
						done_q    <= 1'b0;
						cur_q     <= clip_active ? clip_table_q[0] : start_frame_q;
					end else if (acc && item.func == FUNC_ADVANCE) begin
						elapsed_q <= sum_sat;
					end
				end
				S_PLAN: begin
					if (clip_active) begin
						if (loop_enable_q) begin
							elapsed_q <= ELAPSED_W'(rem_q);
						end else if (n_lt_k) begin
							pos_q     <= pos_c + n[CLIP_AW-1:0];
							elapsed_q <= ELAPSED_W'(rem_q);
						end else begin
							pos_q  <= CLIP_AW'(len_eff - LEN_W'(1));
							done_q <= 1'b1;
						end
					end else if (n != '0) begin
						if (loop_enable_q) begin
							elapsed_q <= ELAPSED_W'(rem_q);
							if (start_frame_q > end_frame_q) begin
								cur_q <= start_frame_q;
							end
						end else if (n_lt_k) begin
							cur_q     <= cur_q + n[FRAME_W-1:0];
							elapsed_q <= ELAPSED_W'(rem_q);
						end else begin
							cur_q  <= end_frame_q;
							done_q <= 1'b1;
						end
					end
				end
				S_WRAP: begin
					if (clip_active) begin
						pos_q <= rem_q[CLIP_AW-1:0];
					end else begin
						cur_q <= start_frame_q + rem_q[FRAME_W-1:0];
					end
				end
				S_SUB: begin
					elapsed_q <= elapsed_q - prod_q[ELAPSED_W-1:0];
				end
				S_CLIP_FETCH: begin
					cur_q <= clip_table_q[pos_q];
				end
				default: begin
					done_q <= done_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && acc && item.func == FUNC_LOAD) begin
			clip_table_q[item.entry_slot] <= item.entry_frame;
		end
	end

	always_ff @(posedge clk) begin
		if (div_run) begin
			rem_q <= trial_sub[TIME_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
			cnt_q <= cnt_q - DIV_CNT_W'(1);
		end else begin
			case (state_q)
				S_IDLE: begin
					quo_q     <= DIV_W'(sum_sat);
					rem_q     <= '0;
					divisor_q <= dur_eff;
					cnt_q     <= DIV_CNT_W'(DIV_W);
				end
				S_PLAN: begin
					quo_q     <= wrap_dividend;
					rem_q     <= '0;
					divisor_q <= wrap_divisor;
					cnt_q     <= DIV_CNT_W'(DIV_W);
					prod_q    <= prod_c;
				end
				S_TILE_LOAD: begin
					quo_q     <= {cur_q, {(DIV_W-FRAME_W){1'b0}}};
					rem_q     <= '0;
					divisor_q <= TIME_W'(cols_eff);
					cnt_q     <= DIV_CNT_W'(FRAME_W);
				end
				S_FINISH: begin
					if (out_free) begin
						result_q.frame_index      <= cur_q;
						result_q.tile_column      <= rem_q[7:0];
						result_q.tile_row_flipped <= flipped;
						result_q.beyond_sheet     <= beyond;
						result_q.finished         <= done_q;
					end
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

endmodule
